// File: sv/atrp_pkg.sv
`default_nettype none

package atrp_pkg;

    // stream widths
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    // relocation types handled
    localparam logic [7:0] RELOC_ABS32    = 8'd2;
    localparam logic [7:0] RELOC_THM_CALL = 8'd10;

    // bits of the branch pair that survive re-encoding
    localparam logic [15:0] HI_KEEP_MASK = 16'hF800;
    localparam logic [15:0] LO_KEEP_MASK = 16'hD000;

    typedef enum logic [1:0] {
        ST_PATCHED      = 2'd0,
        ST_UNSUPPORTED  = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  reloc_type;
        logic [15:0] first_half;
        logic [15:0] second_half;
        logic [31:0] symbol_address;
        logic [31:0] place_address;
    } item_t;

    typedef struct packed {
        logic [15:0] new_first_half;
        logic [15:0] new_second_half;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

// File: sv/atrp_patch.sv
`default_nettype none

module atrp_patch (
    input  atrp_pkg::item_t   item,
    output atrp_pkg::result_t result
);
    import atrp_pkg::*;

    logic        s_bit;
    logic        i1;
    logic        i2;
    logic [31:0] addend;
    logic [31:0] branch;
    logic [31:0] abs_word;
    logic        in_reach;
    logic        nj1;
    logic        nj2;
    logic [15:0] bl_hi;
    logic [15:0] bl_lo;

    // decode the signed 25-bit addend of the bl pair
    assign s_bit  = item.first_half[10];
    assign i1     = ~(item.second_half[13] ^ s_bit);
    assign i2     = ~(item.second_half[11] ^ s_bit);
    assign addend = {{7{s_bit}}, s_bit, i1, i2, item.first_half[9:0],
                     item.second_half[10:0], 1'b0};

    // s + a - p, wrapping
    assign branch = item.symbol_address + addend - item.place_address;

    // reach is a signed 25-bit value: top byte all copies of bit 24
    assign in_reach = (branch[31:24] == {8{branch[24]}});

    // re-encode the pair
    assign nj1   = ~(branch[23] ^ branch[24]);
    assign nj2   = ~(branch[22] ^ branch[24]);
    assign bl_hi = (item.first_half & HI_KEEP_MASK) | {5'd0, branch[24], branch[21:12]};
    assign bl_lo = (item.second_half & LO_KEEP_MASK)
                 | {2'b00, nj1, 1'b0, nj2, branch[11:1]};

    // absolute word, little-endian halves
    assign abs_word = {item.second_half, item.first_half} + item.symbol_address;

    // select by relocation type
    always_comb
    begin
        result.new_first_half  = item.first_half;
        result.new_second_half = item.second_half;
        result.status          = ST_UNSUPPORTED;
        case (item.reloc_type)
            RELOC_ABS32:
            begin
                result.new_first_half  = abs_word[15:0];
                result.new_second_half = abs_word[31:16];
                result.status          = ST_PATCHED;
            end
            RELOC_THM_CALL:
            begin
                if (in_reach)
                begin
                    result.new_first_half  = bl_hi;
                    result.new_second_half = bl_lo;
                    result.status          = ST_PATCHED;
                end
                else
                begin
                    result.status = ST_OUT_OF_RANGE;
                end
            end
            default:
            begin
                result.status = ST_UNSUPPORTED;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/arm_thumb_reloc_patcher_top.sv
// channel | direction | tdata (low bit up)                         | tuser
// s_axis  | in        | first_half, second_half, symbol_address,   | reloc_type
//         |           | place_address (96 bits)                    |
// m_axis  | out       | new_first_half, new_second_half (32 bits)  | status
//
// one request per cycle sustained while m_axis_tready stays high; each request passes
// through the input register and then the result register before it shows on m_axis
// the patch logic is a 32-bit three-operand add, a 32-bit add for ABS32 and a field re-encode
// rst_n clears both valid flags asynchronously; payload registers are not reset
// a stall on m_axis backs up into the input register, then drops s_axis_tready

`default_nettype none

module arm_thumb_reloc_patcher_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // first_half, second_half, symbol_address, place_address
    input  wire logic [atrp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // reloc_type
    input  wire logic [atrp_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // new_first_half, new_second_half
    output logic [atrp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status
    output logic [atrp_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
    import atrp_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t patch_res;
    logic    out_load;
    logic    in_load;

    // handshake: result register frees when empty or taken
    assign out_load       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || out_load;
    assign in_load        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.reloc_type     <= s_axis_tuser;
            in_item_reg.first_half     <= s_axis_tdata[15:0];
            in_item_reg.second_half    <= s_axis_tdata[31:16];
            in_item_reg.symbol_address <= s_axis_tdata[63:32];
            in_item_reg.place_address  <= s_axis_tdata[95:64];
        end
        if (out_load)
        begin
            out_res_reg <= patch_res;
        end
    end

    // relocation patch logic
    atrp_patch u_patch (
        .item   (in_item_reg),
        .result (patch_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.new_second_half, out_res_reg.new_first_half};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

// File: sv/atrp_checker.sv
`default_nettype none

module atrp_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [atrp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [atrp_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [atrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [atrp_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import atrp_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // requests taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // no result without an outstanding request
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pending_reg != 3'd0))
        else $error("result shown with no request outstanding");

    // two register stages hold at most two requests
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two requests held");

    // an empty block always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 3'd0) |-> s_axis_tready)
        else $error("empty block refused a request");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_PATCHED || m_axis_tuser == ST_UNSUPPORTED
                           || m_axis_tuser == ST_OUT_OF_RANGE))
        else $error("undefined status code");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind arm_thumb_reloc_patcher_top atrp_checker u_atrp_checker (.*);

`default_nettype wire
